@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/hbi2d_pkg.sv @@
// Types, constants and helpers for the two-dimensional histogram bin mapper.
`default_nettype none
package hbi2d_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int MAX_BINS_PER_DIM = 256;

    localparam int SCALE_W   = 24;
    localparam int CFG_CNT_W = 9;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_BITS = 16;

    localparam int COUNT_W = $clog2(MAX_BINS_PER_DIM + 1);
    localparam int IDX_W   = $clog2(MAX_BINS_PER_DIM);
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int PROD_W  = SAMPLE_BITS + SCALE_W;
    localparam int POS_W   = COUNT_W + FRAC_BITS;
    localparam int LIN_W   = 16;
    localparam int FRAC_W  = FRAC_BITS + 1;

    localparam logic [POS_W-1:0]  HALF_Q16 = POS_W'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_W-1:0] ONE_Q16  = FRAC_W'(1) << FRAC_BITS;

    localparam int PIPE_DEPTH = 5;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT_Y = 3'd5;

    // Load enables of the lane stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } lane_en_t;

    // What one lane found for its dimension.
    typedef struct packed {
        logic [IDX_W-1:0]  near_idx;
        logic              near_flag;
        logic [IDX_W-1:0]  base_idx;
        logic [FRAC_W-1:0] frac;
        logic              interp_flag;
    } dim_res_t;

    // Saturates a programmed bin count into 2 .. MAX_BINS_PER_DIM.
    function automatic logic [COUNT_W-1:0] eff_count(input logic [CFG_CNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        if (c < CFG_CNT_W'(2))
        begin
            r = COUNT_W'(2);
        end
        else if (32'(c) > MAX_BINS_PER_DIM)
        begin
            r = COUNT_W'(MAX_BINS_PER_DIM);
        end
        else
        begin
            r = COUNT_W'(c);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/hbi2d_lane.sv @@
// One dimension's bin mapping: offset, scale, clamp, then nearest and interpolation bins.
`default_nettype none
module hbi2d_lane (
    input  wire logic                                  clk,
    input  wire hbi2d_pkg::lane_en_t                   en,
    input  wire logic signed [hbi2d_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic signed [hbi2d_pkg::SAMPLE_BITS-1:0] range_min,
    input  wire logic [hbi2d_pkg::SCALE_W-1:0]         scale,
    input  wire logic [hbi2d_pkg::COUNT_W-1:0]         count,
    output hbi2d_pkg::dim_res_t                        res
);

    logic signed [hbi2d_pkg::DIFF_W-1:0] diff;
    logic                                 below;
    logic [hbi2d_pkg::SAMPLE_BITS-1:0]    mag_reg;
    logic                                 zero_reg;
    logic [hbi2d_pkg::PROD_W-1:0]         prod_reg;
    logic [hbi2d_pkg::POS_W-1:0]          top;
    logic [hbi2d_pkg::POS_W-1:0]          pos_next;
    logic [hbi2d_pkg::POS_W-1:0]          pos_reg;
    logic [hbi2d_pkg::COUNT_W-1:0]        fl;
    logic [hbi2d_pkg::COUNT_W-1:0]        cm1;
    logic [hbi2d_pkg::COUNT_W-1:0]        cm2;
    logic [hbi2d_pkg::POS_W-1:0]          p;
    logic [hbi2d_pkg::COUNT_W-1:0]        b;
    hbi2d_pkg::dim_res_t                  res_next;
    hbi2d_pkg::dim_res_t                  res_reg;

    assign diff  = hbi2d_pkg::DIFF_W'(sample) - hbi2d_pkg::DIFF_W'(range_min);
    assign below = diff[hbi2d_pkg::DIFF_W-1] || (diff == '0);

    // The upper clamp sits at count << 16, which matches clipping the sample to its range.
    assign top = {count, hbi2d_pkg::FRAC_BITS'(0)};
    assign pos_next = (prod_reg > hbi2d_pkg::PROD_W'(top)) ? top
                                                           : prod_reg[hbi2d_pkg::POS_W-1:0];

    assign fl  = pos_reg[hbi2d_pkg::POS_W-1:hbi2d_pkg::FRAC_BITS];
    assign cm1 = count - hbi2d_pkg::COUNT_W'(1);
    assign cm2 = count - hbi2d_pkg::COUNT_W'(2);
    assign p   = pos_reg - hbi2d_pkg::HALF_Q16;
    assign b   = p[hbi2d_pkg::POS_W-1:hbi2d_pkg::FRAC_BITS];

    always_comb
    begin
        if (fl >= count)
        begin
            res_next.near_idx  = cm1[hbi2d_pkg::IDX_W-1:0];
            res_next.near_flag = 1'b1;
        end
        else
        begin
            res_next.near_idx  = fl[hbi2d_pkg::IDX_W-1:0];
            res_next.near_flag = 1'b0;
        end

        if (pos_reg < hbi2d_pkg::HALF_Q16)
        begin
            res_next.base_idx    = '0;
            res_next.frac        = '0;
            res_next.interp_flag = 1'b1;
        end
        else if (b >= cm1)
        begin
            res_next.base_idx    = cm2[hbi2d_pkg::IDX_W-1:0];
            res_next.frac        = hbi2d_pkg::ONE_Q16;
            res_next.interp_flag = 1'b1;
        end
        else
        begin
            res_next.base_idx    = b[hbi2d_pkg::IDX_W-1:0];
            res_next.frac        = {1'b0, p[hbi2d_pkg::FRAC_BITS-1:0]};
            res_next.interp_flag = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            mag_reg  <= diff[hbi2d_pkg::SAMPLE_BITS-1:0];
            zero_reg <= below;
        end
        if (en.s2)
        begin
            prod_reg <= zero_reg ? '0
                                 : hbi2d_pkg::PROD_W'(mag_reg) * hbi2d_pkg::PROD_W'(scale);
        end
        if (en.s3)
        begin
            pos_reg <= pos_next;
        end
        if (en.s4)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

@@ rtl/hbi2d_merge.sv @@
// Combines the two lanes into linear bin indices and flags, held in the output register.
`default_nettype none
module hbi2d_merge (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire hbi2d_pkg::dim_res_t                 res_x,
    input  wire hbi2d_pkg::dim_res_t                 res_y,
    input  wire logic [hbi2d_pkg::COUNT_W-1:0]       count_x,
    output logic [hbi2d_pkg::LIN_W-1:0]              bin_index,
    output logic                                     upper_clipped,
    output logic [hbi2d_pkg::LIN_W-1:0]              interp_base_index,
    output logic [hbi2d_pkg::FRAC_W-1:0]             interp_frac_x,
    output logic [hbi2d_pkg::FRAC_W-1:0]             interp_frac_y,
    output logic                                     interp_clipped
);

    localparam int SUM_W = hbi2d_pkg::IDX_W + hbi2d_pkg::COUNT_W + 1;

    logic [SUM_W-1:0] near_sum;
    logic [SUM_W-1:0] base_sum;

    // Dimension one strides by the bin count of dimension zero.
    assign near_sum = SUM_W'(res_x.near_idx) + SUM_W'(res_y.near_idx) * SUM_W'(count_x);
    assign base_sum = SUM_W'(res_x.base_idx) + SUM_W'(res_y.base_idx) * SUM_W'(count_x);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bin_index         <= near_sum[hbi2d_pkg::LIN_W-1:0];
            upper_clipped     <= res_x.near_flag | res_y.near_flag;
            interp_base_index <= base_sum[hbi2d_pkg::LIN_W-1:0];
            interp_frac_x     <= res_x.frac;
            interp_frac_y     <= res_y.frac;
            interp_clipped    <= res_x.interp_flag | res_y.interp_flag;
        end
    end

endmodule
`default_nettype wire

@@ rtl/histogram_bin_index_2d_unit.sv @@
// Top level of the two-dimensional histogram bin mapper.
// Each accepted input item (sample_x, sample_y) yields one result item; two lanes map
// x and y through offset, multiply, clamp and bin selection, and a final stage forms
// the linear indices. A new item enters every cycle unless s_axis_tready is low;
// s_axis_tready drops only when all five stages hold items and the output item is not taken.
// Configuration writes take effect at once and are meant for times the pipeline is empty.
`default_nettype none
`include "assert_macros.svh"
module histogram_bin_index_2d_unit (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // sample_x [15:0], sample_y [31:16]
    input  wire logic [hbi2d_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // bin_index [15:0], upper_clipped [16], interp_base_index [32:17],
    // interp_frac_x [49:33], interp_frac_y [66:50], interp_clipped [67], zero [71:68]
    output logic [hbi2d_pkg::OUT_DATA_W-1:0]             m_axis_tdata,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [hbi2d_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [hbi2d_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int D = hbi2d_pkg::PIPE_DEPTH;

    logic signed [hbi2d_pkg::SAMPLE_BITS-1:0] range_min_x_reg, range_min_x_next;
    logic signed [hbi2d_pkg::SAMPLE_BITS-1:0] range_min_y_reg, range_min_y_next;
    logic [hbi2d_pkg::SCALE_W-1:0]            bin_scale_x_reg, bin_scale_x_next;
    logic [hbi2d_pkg::SCALE_W-1:0]            bin_scale_y_reg, bin_scale_y_next;
    logic [hbi2d_pkg::CFG_CNT_W-1:0]          bin_count_x_reg, bin_count_x_next;
    logic [hbi2d_pkg::CFG_CNT_W-1:0]          bin_count_y_reg, bin_count_y_next;

    logic [hbi2d_pkg::COUNT_W-1:0] count_x;
    logic [hbi2d_pkg::COUNT_W-1:0] count_y;

    logic [D-1:0] valid_reg;
    logic [D-1:0] valid_next;
    logic [D-1:0] adv;
    logic [D-1:0] prev_valid;

    hbi2d_pkg::lane_en_t lane_en;
    hbi2d_pkg::dim_res_t res_x;
    hbi2d_pkg::dim_res_t res_y;

    logic [hbi2d_pkg::LIN_W-1:0]  bin_index;
    logic                         upper_clipped;
    logic [hbi2d_pkg::LIN_W-1:0]  interp_base_index;
    logic [hbi2d_pkg::FRAC_W-1:0] interp_frac_x;
    logic [hbi2d_pkg::FRAC_W-1:0] interp_frac_y;
    logic                         interp_clipped;

    always_comb
    begin
        range_min_x_next = range_min_x_reg;
        range_min_y_next = range_min_y_reg;
        bin_scale_x_next = bin_scale_x_reg;
        bin_scale_y_next = bin_scale_y_reg;
        bin_count_x_next = bin_count_x_reg;
        bin_count_y_next = bin_count_y_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hbi2d_pkg::REG_RANGE_MIN_X:
                    range_min_x_next = cfg_wdata[hbi2d_pkg::SAMPLE_BITS-1:0];
                hbi2d_pkg::REG_RANGE_MIN_Y:
                    range_min_y_next = cfg_wdata[hbi2d_pkg::SAMPLE_BITS-1:0];
                hbi2d_pkg::REG_BIN_SCALE_X:
                    bin_scale_x_next = cfg_wdata[hbi2d_pkg::SCALE_W-1:0];
                hbi2d_pkg::REG_BIN_SCALE_Y:
                    bin_scale_y_next = cfg_wdata[hbi2d_pkg::SCALE_W-1:0];
                hbi2d_pkg::REG_BIN_COUNT_X:
                    bin_count_x_next = cfg_wdata[hbi2d_pkg::CFG_CNT_W-1:0];
                hbi2d_pkg::REG_BIN_COUNT_Y:
                    bin_count_y_next = cfg_wdata[hbi2d_pkg::CFG_CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign count_x = hbi2d_pkg::eff_count(bin_count_x_reg);
    assign count_y = hbi2d_pkg::eff_count(bin_count_y_reg);

    // A stage loads when it is empty or its item moves on; bubbles close up.
    assign prev_valid = {valid_reg[D-2:0], s_axis_tvalid};
    always_comb
    begin
        adv[D-1] = !valid_reg[D-1] || m_axis_tready;
        for (int i = D - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        for (int i = 0; i < D; i++)
        begin
            valid_next[i] = adv[i] ? prev_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_x_reg <= '0;
            range_min_y_reg <= '0;
            bin_scale_x_reg <= hbi2d_pkg::SCALE_W'(65536);
            bin_scale_y_reg <= hbi2d_pkg::SCALE_W'(65536);
            bin_count_x_reg <= hbi2d_pkg::CFG_CNT_W'(16);
            bin_count_y_reg <= hbi2d_pkg::CFG_CNT_W'(16);
            valid_reg       <= '0;
        end
        else
        begin
            range_min_x_reg <= range_min_x_next;
            range_min_y_reg <= range_min_y_next;
            bin_scale_x_reg <= bin_scale_x_next;
            bin_scale_y_reg <= bin_scale_y_next;
            bin_count_x_reg <= bin_count_x_next;
            bin_count_y_reg <= bin_count_y_next;
            valid_reg       <= valid_next;
        end
    end

    assign lane_en.s1 = adv[0];
    assign lane_en.s2 = adv[1];
    assign lane_en.s3 = adv[2];
    assign lane_en.s4 = adv[3];

    hbi2d_lane u_lane_x (
        .clk       (clk),
        .en        (lane_en),
        .sample    (s_axis_tdata[hbi2d_pkg::SAMPLE_BITS-1:0]),
        .range_min (range_min_x_reg),
        .scale     (bin_scale_x_reg),
        .count     (count_x),
        .res       (res_x)
    );

    hbi2d_lane u_lane_y (
        .clk       (clk),
        .en        (lane_en),
        .sample    (s_axis_tdata[2*hbi2d_pkg::SAMPLE_BITS-1:hbi2d_pkg::SAMPLE_BITS]),
        .range_min (range_min_y_reg),
        .scale     (bin_scale_y_reg),
        .count     (count_y),
        .res       (res_y)
    );

    hbi2d_merge u_merge (
        .clk               (clk),
        .en                (adv[D-1]),
        .res_x             (res_x),
        .res_y             (res_y),
        .count_x           (count_x),
        .bin_index         (bin_index),
        .upper_clipped     (upper_clipped),
        .interp_base_index (interp_base_index),
        .interp_frac_x     (interp_frac_x),
        .interp_frac_y     (interp_frac_y),
        .interp_clipped    (interp_clipped)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[D-1];
    assign m_axis_tdata  = {4'b0000, interp_clipped, interp_frac_y, interp_frac_x,
                            interp_base_index, upper_clipped, bin_index};

    // A full fraction only appears on an upper interpolation clip.
    `ASSERT_IMPL(a_frac_x_one_clipped, clk, rst_n,
        m_axis_tvalid && interp_frac_x[hbi2d_pkg::FRAC_BITS],
        interp_clipped && (interp_frac_x[hbi2d_pkg::FRAC_BITS-1:0] == '0))
    `ASSERT_IMPL(a_frac_y_one_clipped, clk, rst_n,
        m_axis_tvalid && interp_frac_y[hbi2d_pkg::FRAC_BITS],
        interp_clipped && (interp_frac_y[hbi2d_pkg::FRAC_BITS-1:0] == '0))
    // Input is refused only when every stage holds an item.
    `ASSERT_IMPL(a_stall_only_when_full, clk, rst_n,
        !s_axis_tready, (valid_reg == '1) && !m_axis_tready)
    // An accepted item is in the first stage on the next cycle.
    `ASSERT_NEXT(a_accept_fills_stage1, clk, rst_n,
        s_axis_tvalid && s_axis_tready, valid_reg[0])

endmodule
`default_nettype wire

@@ sim/tb_histogram_bin_index_2d_unit.sv @@
// Self-checking testbench for the two-dimensional histogram bin mapper.
module tb_histogram_bin_index_2d_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned HALF_BIN = 64'd32768;
    localparam logic [16:0]     ONE_FRAC = 17'h10000;
    localparam int PHASES           = 12;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int LONG_HOLD_CYCLES = 300;

    // What one dimension contributes to a result item.
    typedef struct packed {
        logic [15:0] near;
        logic        near_clip;
        logic [15:0] base;
        logic [16:0] frac;
        logic        interp_clip;
    } axis_bin_t;

    typedef struct packed {
        logic [15:0] bin_index;
        logic        upper_clipped;
        logic [15:0] interp_base_index;
        logic [16:0] interp_frac_x;
        logic [16:0] interp_frac_y;
        logic        interp_clipped;
    } bin_result_t;

    class bin_map_checker;
        logic [15:0] min_x, min_y;
        logic [23:0] scale_x, scale_y;
        logic [8:0]  count_x, count_y;
        bin_result_t expected_bins[$];
        int errors;

        function new();
            min_x   = 16'd0;
            min_y   = 16'd0;
            scale_x = 24'd65536;
            scale_y = 24'd65536;
            count_x = 9'd16;
            count_y = 9'd16;
            errors  = 0;
        endfunction

        function void write_reg(logic [hbi2d_pkg::CFG_IDX_W-1:0] idx,
                                logic [hbi2d_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                hbi2d_pkg::REG_RANGE_MIN_X: min_x = val[15:0];
                hbi2d_pkg::REG_RANGE_MIN_Y: min_y = val[15:0];
                hbi2d_pkg::REG_BIN_SCALE_X: scale_x = val[23:0];
                hbi2d_pkg::REG_BIN_SCALE_Y: scale_y = val[23:0];
                hbi2d_pkg::REG_BIN_COUNT_X: count_x = val[8:0];
                hbi2d_pkg::REG_BIN_COUNT_Y: count_y = val[8:0];
                default: ;
            endcase
        endfunction

        function int sat_count(logic [8:0] c);
            if (c < 9'd2)
            begin
                return 2;
            end
            if (int'(c) > hbi2d_pkg::MAX_BINS_PER_DIM)
            begin
                return hbi2d_pkg::MAX_BINS_PER_DIM;
            end
            return int'(c);
        endfunction

        function axis_bin_t map_axis(logic [15:0] s, logic [15:0] rmin, logic [23:0] scale,
                                     int cnt);
            axis_bin_t r;
            longint diff;
            longint unsigned pos, top, shifted;
            diff = longint'($signed(s)) - longint'($signed(rmin));
            top = longint'(cnt) << 16;
            if (diff <= 0)
            begin
                pos = 0;
            end
            else
            begin
                pos = diff * longint'(scale);
                if (pos > top)
                begin
                    pos = top;
                end
            end
            if ((pos >> 16) >= cnt)
            begin
                r.near      = 16'(cnt - 1);
                r.near_clip = 1'b1;
            end
            else
            begin
                r.near      = 16'(pos >> 16);
                r.near_clip = 1'b0;
            end
            if (pos < HALF_BIN)
            begin
                r.base        = 16'd0;
                r.frac        = 17'd0;
                r.interp_clip = 1'b1;
            end
            else
            begin
                shifted = pos - HALF_BIN;
                // The upper corner would fall outside the range, so pin to the last pair.
                if ((shifted >> 16) >= cnt - 1)
                begin
                    r.base        = 16'(cnt - 2);
                    r.frac        = ONE_FRAC;
                    r.interp_clip = 1'b1;
                end
                else
                begin
                    r.base        = 16'(shifted >> 16);
                    r.frac        = {1'b0, shifted[15:0]};
                    r.interp_clip = 1'b0;
                end
            end
            return r;
        endfunction

        function void note_sample(logic [15:0] sx, logic [15:0] sy);
            int cx, cy;
            axis_bin_t ax, ay;
            bin_result_t e;
            cx = sat_count(count_x);
            cy = sat_count(count_y);
            ax = map_axis(sx, min_x, scale_x, cx);
            ay = map_axis(sy, min_y, scale_y, cy);
            e.bin_index         = 16'(int'(ax.near) + int'(ay.near) * cx);
            e.upper_clipped     = ax.near_clip | ay.near_clip;
            e.interp_base_index = 16'(int'(ax.base) + int'(ay.base) * cx);
            e.interp_frac_x     = ax.frac;
            e.interp_frac_y     = ay.frac;
            e.interp_clipped    = ax.interp_clip | ay.interp_clip;
            expected_bins.push_back(e);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [hbi2d_pkg::OUT_DATA_W-1:0] d);
            bin_result_t want;
            if (expected_bins.size() == 0)
            begin
                $display("%0t: result item with nothing expected, expected none, actual %h",
                         $time, d);
                errors++;
                return;
            end
            want = expected_bins.pop_front();
            compare_field("bin_index", want.bin_index, d[15:0]);
            compare_field("upper_clipped", want.upper_clipped, d[16]);
            compare_field("interp_base_index", want.interp_base_index, d[32:17]);
            compare_field("interp_frac_x", want.interp_frac_x, d[49:33]);
            compare_field("interp_frac_y", want.interp_frac_y, d[66:50]);
            compare_field("interp_clipped", want.interp_clipped, d[67]);
            compare_field("padding", 0, d[71:68]);
        endfunction

        function int pending();
            return expected_bins.size();
        endfunction
    endclass

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    logic [hbi2d_pkg::IN_DATA_W-1:0]        s_axis_tdata = '0;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    logic [hbi2d_pkg::OUT_DATA_W-1:0]       m_axis_tdata;
    logic                                   cfg_wr_en = 1'b0;
    logic [hbi2d_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [hbi2d_pkg::CFG_DATA_W-1:0]       cfg_wdata = '0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit long_hold  = 1'b0;

    bin_map_checker sb = new();

    int directed_x[20] = '{0, 1, 0, 1, 8, 15, 16, 17, 3, -1,
                           -1, 5, -32768, 32767, -32768, 32767, 14, 2, 21845, -21846};
    int directed_y[20] = '{0, 0, 1, 1, 7, 15, 16, 3, 17, -1,
                           5, -1, -32768, 32767, 32767, -32768, 2, 14, -21846, 21845};

    histogram_bin_index_2d_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("tb_histogram_bin_index_2d_unit failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (long_hold)
                begin
                    long_hold  = 1'b0;
                    stall_left = LONG_HOLD_CYCLES;
                end
                else if (rx_idle_on && $urandom_range(0, 4) == 0)
                begin
                    stall_left = $urandom_range(1, 9);
                end
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [15:0] sx, input logic [15:0] sy);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sy, sx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(sx, sy);
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (hbi2d_pkg::PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hbi2d_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hbi2d_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic [23:0] pick_scale();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(1, 24'h3ffff));
            1: return 24'($urandom_range(24'h100, 24'h10000));
            2: return 24'($urandom());
            default: return 24'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [8:0] pick_count();
        case ($urandom_range(0, 4))
            0: return 9'($urandom());
            1: return 9'($urandom_range(2, 8));
            default: return 9'($urandom_range(2, 256));
        endcase
    endfunction

    function automatic logic [15:0] pick_min();
        if ($urandom_range(0, 1) == 0)
        begin
            return 16'($urandom());
        end
        return 16'(int'($urandom_range(0, 4000)) - 2000);
    endfunction

    task automatic set_phase_regs(input int phase);
        logic [15:0] mx, my;
        logic [23:0] kx, ky;
        logic [8:0]  nx, ny;
        case (phase)
            1:
            begin
                mx = 16'h8000; my = 16'h7fff; kx = 24'hffffff; ky = 24'd0;
                nx = 9'd0;     ny = 9'h1ff;
            end
            2:
            begin
                mx = 16'h7fff; my = 16'h8000; kx = 24'd0; ky = 24'hffffff;
                nx = 9'd256;   ny = 9'd1;
            end
            3:
            begin
                mx = 16'd0; my = 16'hff9c; kx = 24'h000100; ky = 24'h00c000;
                nx = 9'd257; ny = 9'd2;
            end
            default:
            begin
                mx = pick_min();   my = pick_min();
                kx = pick_scale(); ky = pick_scale();
                nx = pick_count(); ny = pick_count();
            end
        endcase
        write_reg(hbi2d_pkg::REG_RANGE_MIN_X, 24'(mx));
        write_reg(hbi2d_pkg::REG_RANGE_MIN_Y, 24'(my));
        write_reg(hbi2d_pkg::REG_BIN_SCALE_X, kx);
        write_reg(hbi2d_pkg::REG_BIN_SCALE_Y, ky);
        write_reg(hbi2d_pkg::REG_BIN_COUNT_X, 24'(nx));
        write_reg(hbi2d_pkg::REG_BIN_COUNT_Y, 24'(ny));
    endtask

    // Mostly samples around the programmed range, so that every bin and both clips are hit.
    function automatic logic [15:0] pick_sample(logic [15:0] rmin, logic [23:0] scale,
                                                logic [8:0] raw_count);
        int span;
        if ($urandom_range(0, 9) < 3)
        begin
            return 16'($urandom());
        end
        if (scale == 24'd0)
        begin
            span = 256;
        end
        else
        begin
            span = int'((longint'(sb.sat_count(raw_count)) << 16) / longint'(scale)) + 1;
            if (span > 70000)
            begin
                span = 70000;
            end
        end
        return 16'(int'($signed(rmin)) + int'($urandom_range(0, span + span / 4 + 2))
                   - span / 8 - 1);
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_x[i])
        begin
            send_sample(16'(directed_x[i]), 16'(directed_y[i]));
        end
        drain();

        for (int phase = 1; phase <= PHASES; phase++)
        begin
            set_phase_regs(phase);
            if (phase == 4)
            begin
                // Sender keeps offering while the receiver holds off, so the pipe fills up.
                tx_idle_on = 1'b0;
                long_hold  = 1'b1;
            end
            if (phase == PHASES)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            repeat (ITEMS_PER_PHASE)
            begin
                send_sample(pick_sample(sb.min_x, sb.scale_x, sb.count_x),
                            pick_sample(sb.min_y, sb.scale_y, sb.count_y));
            end
            drain();
            if (phase != PHASES)
            begin
                tx_idle_on = 1'b1;
            end
        end

        repeat (hbi2d_pkg::PIPE_DEPTH * 4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("tb_histogram_bin_index_2d_unit passed");
        end
        else
        begin
            $display("tb_histogram_bin_index_2d_unit failed");
        end
        $finish;
    end

endmodule
